[hw/rtl/lpht_pkg.sv]
// lpht_pkg: sizes, result codes and controller/datapath interface types
// for the linear probing hash table; no dependencies
package lpht_pkg;

    // table size must be a power of two; home slot and wraparound are taken modulo the table size
    localparam int TABLE_SIZE = 16;
    localparam int KEY_BITS   = 16;
    localparam int KEY_IN_W   = 16;
    localparam int SLOT_OUT_W = 4;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    localparam int COUNT_W    = $clog2(TABLE_SIZE + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [SLOT_W-1:0]   slot_idx_t;
    typedef logic [COUNT_W-1:0]  count_t;

    // controller to datapath
    typedef struct packed {
        logic start;   // request accepted: latch key, read home slot
        logic step;    // advance to next slot
        logic finish;  // commit insert and load result register
    } lpht_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic decide;    // current probe ends the walk
        logic out_free;  // result register can take a new result
    } lpht_sts_t;

endpackage

[hw/rtl/linear_probe_hash_table_top.sv]
// linear_probe_hash_table_top: top level of the linear probing hash table
// depends on lpht_pkg, lpht_ctrl, lpht_dp
//
// Open-addressing hash table of 16 slots holding 16-bit keys. Each request
// is an insert (opcode 0) or a search (opcode 1) and gives exactly one
// result: status 0 inserted, 1 found, 2 not found, 3 table full, plus the
// slot stored to or found at (0 otherwise). The home slot is the low bits
// of the key; the walk steps forward one slot per cycle with wraparound, a
// pace set by the single read port of the key store. Duplicate inserts
// store another copy; a search returns the first copy on the probe path.
// An insert into a table that already holds 16 keys returns table full at
// once. One request is worked on at a time; the finished result sits in an
// output register, so a request can be accepted while the previous result
// waits, and the walk pauses at its last probe until the result register
// frees up. Reset empties the table at once (occupied bits are flip-flops).
module linear_probe_hash_table_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                opcode,
    input  logic [lpht_pkg::KEY_IN_W-1:0]       key,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lpht_pkg::STATUS_W-1:0]       status,
    output logic [lpht_pkg::SLOT_OUT_W-1:0]     slot
);

    // command and status between sequencer and datapath
    lpht_pkg::lpht_cmd_t cmd;
    lpht_pkg::lpht_sts_t sts;

    // sequencer: idle / probe, issues start, step and finish
    lpht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: key store, occupied bits, count, probe pointer, result register
    lpht_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .opcode    (opcode),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .slot      (slot)
    );

endmodule

[hw/rtl/lpht_ctrl.sv]
// lpht_ctrl: request sequencer for the hash table probe walk
// depends on lpht_pkg
module lpht_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lpht_pkg::lpht_sts_t sts,
    output lpht_pkg::lpht_cmd_t cmd
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_PROBE = 1'b1;

    logic state_reg;
    logic state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (!sts.decide)
                begin
                    cmd.step = 1'b1;
                end
                else if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_no_step_and_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.step && cmd.finish))
        else $error("step and finish in same cycle");

    a_finish_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> in_ready)
        else $error("not idle after finish");

    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> !in_ready)
        else $error("still idle after start");

endmodule

[hw/rtl/lpht_dp.sv]
// lpht_dp: key store, occupied bits, entry count, probe pointer and result register
// depends on lpht_pkg
module lpht_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lpht_pkg::lpht_cmd_t                 cmd,
    output lpht_pkg::lpht_sts_t                 sts,
    input  logic                                opcode,
    input  logic [lpht_pkg::KEY_IN_W-1:0]       key,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lpht_pkg::STATUS_W-1:0]       status,
    output logic [lpht_pkg::SLOT_OUT_W-1:0]     slot
);

    lpht_pkg::key_t key_store [lpht_pkg::TABLE_SIZE];

    logic [lpht_pkg::TABLE_SIZE-1:0] occupied_reg;
    lpht_pkg::count_t                count_reg;
    lpht_pkg::key_t                  key_reg;
    logic                            op_reg;
    logic                            full_reg;
    lpht_pkg::slot_idx_t             probe_reg;
    lpht_pkg::slot_idx_t             cnt_reg;
    lpht_pkg::key_t                  rd_data_reg;
    logic                            out_valid_reg;
    logic [lpht_pkg::STATUS_W-1:0]   status_reg;
    logic [lpht_pkg::SLOT_OUT_W-1:0] slot_reg;

    lpht_pkg::key_t                  key_in;
    lpht_pkg::slot_idx_t             home_in;
    lpht_pkg::slot_idx_t             probe_next;
    lpht_pkg::slot_idx_t             rd_addr;
    logic                            occ_hit;
    logic                            key_match;
    logic                            last_probe;
    logic                            do_insert;
    logic                            walk_done;
    logic [lpht_pkg::STATUS_W-1:0]   status_next;

    assign key_in     = lpht_pkg::KEY_BITS'(key);
    assign home_in    = lpht_pkg::SLOT_W'(key_in % lpht_pkg::TABLE_SIZE);
    assign probe_next = lpht_pkg::SLOT_W'((32'(probe_reg) + 32'd1) % lpht_pkg::TABLE_SIZE);
    assign rd_addr    = cmd.start ? home_in : probe_next;

    assign occ_hit    = occupied_reg[probe_reg];
    assign key_match  = occ_hit && (rd_data_reg == key_reg);
    assign last_probe = (cnt_reg == lpht_pkg::SLOT_W'(lpht_pkg::TABLE_SIZE - 1));

    always_comb
    begin
        do_insert   = 1'b0;
        status_next = lpht_pkg::ST_NOT_FOUND;
        walk_done   = 1'b0;
        priority if (full_reg)
        begin
            status_next = lpht_pkg::ST_FULL;
            walk_done   = 1'b1;
        end
        else if (op_reg == lpht_pkg::OP_INSERT)
        begin
            walk_done = !occ_hit || last_probe;
            if (!occ_hit)
            begin
                do_insert   = 1'b1;
                status_next = lpht_pkg::ST_INSERTED;
            end
            else
            begin
                status_next = lpht_pkg::ST_FULL;
            end
        end
        else
        begin
            walk_done   = !occ_hit || key_match || last_probe;
            status_next = key_match ? lpht_pkg::ST_FOUND : lpht_pkg::ST_NOT_FOUND;
        end
    end

    assign sts = '{decide: walk_done, out_free: (!out_valid_reg || out_ready)};

    // key store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.finish && do_insert)
        begin
            key_store[probe_reg] <= key_reg;
        end
        if (cmd.start || cmd.step)
        begin
            rd_data_reg <= key_store[rd_addr];
        end
    end

    // request payload and probe pointer
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg   <= key_in;
            op_reg    <= opcode;
            probe_reg <= home_in;
            cnt_reg   <= '0;
            full_reg  <= (opcode == lpht_pkg::OP_INSERT)
                         && (count_reg >= lpht_pkg::COUNT_W'(lpht_pkg::TABLE_SIZE));
        end
        else if (cmd.step)
        begin
            probe_reg <= probe_next;
            cnt_reg   <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish && do_insert)
            begin
                occupied_reg[probe_reg] <= 1'b1;
                count_reg               <= count_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg <= status_next;
            if (status_next == lpht_pkg::ST_INSERTED || status_next == lpht_pkg::ST_FOUND)
            begin
                slot_reg <= lpht_pkg::SLOT_OUT_W'(probe_reg);
            end
            else
            begin
                slot_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lpht_pkg::COUNT_W'(lpht_pkg::TABLE_SIZE))
        else $error("entry count above table size");

    a_finish_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> sts.out_free)
        else $error("result overwritten before taken");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && do_insert) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not bump entry count");

    a_count_matches_bits: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == $countones(occupied_reg))
        else $error("entry count disagrees with occupied bits");

endmodule

[bench/tb_linear_probe_hash_table_top.sv]
// tb_linear_probe_hash_table_top: self-checking bench for the linear probing hash table
// drives inserts and searches, predicts every reply in a scoreboard class and
// compares status and slot; depends on lpht_pkg and linear_probe_hash_table_top
`timescale 1ns / 100ps

module tb_linear_probe_hash_table_top;

    localparam int RESET_CYCLES    = 9;
    localparam int RANDOM_REQUESTS = 380;
    localparam int MAX_GAP         = 13;
    localparam int HOLD_AT_RESULT  = 150;   // reply count at which the sink stalls
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_AT        = 250;   // random request index of the drain pause
    localparam int TAIL_CYCLES     = 40;    // a bit over two worst-case walks
    localparam int CYCLE_LIMIT     = 200000;

    typedef struct packed {
        logic [lpht_pkg::STATUS_W-1:0]   status;
        logic [lpht_pkg::SLOT_OUT_W-1:0] slot;
    } hash_reply_t;

    // mirror of the table contents and queue of replies still owed by the block
    class hash_table_scoreboard;
        lpht_pkg::key_t   key_store [lpht_pkg::TABLE_SIZE];
        bit               slot_used [lpht_pkg::TABLE_SIZE];
        lpht_pkg::count_t entries;
        hash_reply_t      owed_replies[$];
        int               errors;
        int               status_tally[4];

        function new();
            for (int i = 0; i < lpht_pkg::TABLE_SIZE; i++)
            begin
                key_store[i] = '0;
                slot_used[i] = 1'b0;
            end
            entries = '0;
            errors  = 0;
            for (int i = 0; i < 4; i++)
                status_tally[i] = 0;
        endfunction

        // walk the mirrored table the way the block does and queue the reply
        function void note_request(logic op, logic [lpht_pkg::KEY_IN_W-1:0] raw_key);
            lpht_pkg::key_t      k;
            lpht_pkg::slot_idx_t s;
            hash_reply_t         r;
            k        = raw_key[lpht_pkg::KEY_BITS-1:0];
            s        = lpht_pkg::slot_idx_t'(k % lpht_pkg::TABLE_SIZE);
            r.status = lpht_pkg::ST_NOT_FOUND;
            r.slot   = '0;
            if (op == lpht_pkg::OP_INSERT)
            begin
                r.status = lpht_pkg::ST_FULL;
                if (entries < lpht_pkg::TABLE_SIZE)
                begin
                    for (int n = 0; n < lpht_pkg::TABLE_SIZE; n++)
                    begin
                        if (!slot_used[s])
                        begin
                            key_store[s] = k;
                            slot_used[s] = 1'b1;
                            entries      = entries + 1'b1;
                            r.status     = lpht_pkg::ST_INSERTED;
                            r.slot       = lpht_pkg::SLOT_OUT_W'(s);
                            break;
                        end
                        s = lpht_pkg::slot_idx_t'((s + 1) % lpht_pkg::TABLE_SIZE);
                    end
                end
            end
            else
            begin
                // stops at an empty slot, the first matching copy, or after a full lap
                for (int n = 0; n < lpht_pkg::TABLE_SIZE; n++)
                begin
                    if (!slot_used[s])
                        break;
                    if (key_store[s] == k)
                    begin
                        r.status = lpht_pkg::ST_FOUND;
                        r.slot   = lpht_pkg::SLOT_OUT_W'(s);
                        break;
                    end
                    s = lpht_pkg::slot_idx_t'((s + 1) % lpht_pkg::TABLE_SIZE);
                end
            end
            owed_replies.push_back(r);
        endfunction

        function void check_result(logic [lpht_pkg::STATUS_W-1:0] got_status,
                                   logic [lpht_pkg::SLOT_OUT_W-1:0] got_slot);
            hash_reply_t want;
            if (owed_replies.size() == 0)
            begin
                errors++;
                $display("%0t: reply with none owed: status %0d slot %0d",
                         $time, got_status, got_slot);
                return;
            end
            want = owed_replies.pop_front();
            if (got_status !== want.status)
            begin
                errors++;
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, got_status);
            end
            if (got_slot !== want.slot)
            begin
                errors++;
                $display("%0t: slot mismatch: expected %0d, actual %0d",
                         $time, want.slot, got_slot);
            end
            status_tally[want.status]++;
        endfunction

        function int pending();
            return owed_replies.size();
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic                            opcode;
    logic [lpht_pkg::KEY_IN_W-1:0]   key;
    logic                            out_valid;
    logic                            out_ready;
    logic [lpht_pkg::STATUS_W-1:0]   status;
    logic [lpht_pkg::SLOT_OUT_W-1:0] slot;

    hash_table_scoreboard sb;
    lpht_pkg::key_t       stored_keys[$];   // keys known to be in the table
    int                   requests_sent = 0;
    int                   cycle_count   = 0;

    linear_probe_hash_table_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .slot      (slot)
    );

    initial
        clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // both channels are sampled at the rising edge, before any register updates
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(opcode, key);
            if (out_valid && out_ready)
                sb.check_result(status, slot);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d replies still owed", $time, sb.pending());
            $display("tb_linear_probe_hash_table_top: errors");
            $finish;
        end
    end

    // idle cycles before the next handshake; every third block of 50 runs back to back
    function automatic int draw_gap(int idx);
        if ((idx / 50) % 3 == 2)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // one request: optional idle gap, then hold valid until accepted
    task automatic send_request(logic op, lpht_pkg::key_t k);
        int gap;
        gap = draw_gap(requests_sent);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        opcode   <= op;
        key      <= lpht_pkg::KEY_IN_W'(k);
        do @(posedge clk); while (!in_ready);
        requests_sent++;
    endtask

    task automatic idle_request();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic insert_key(lpht_pkg::key_t k);
        stored_keys.push_back(k);
        send_request(lpht_pkg::OP_INSERT, k);
    endtask

    // result side: random stalls, one long stall so the block backs up
    task automatic result_sink();
        int taken;
        int gap;
        bit held;
        taken = 0;
        held  = 1'b0;
        forever
        begin
            if (taken == HOLD_AT_RESULT && !held)
            begin
                held = 1'b1;
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gap = draw_gap(taken);
            if (gap > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    endtask

    task automatic run_directed();
        // empty table: home slot empty, walk stops at once
        send_request(lpht_pkg::OP_SEARCH, 16'h0000);
        send_request(lpht_pkg::OP_SEARCH, 16'hFFFF);
        // extreme keys, a collision at slot 0 and a walk that wraps past slot 15
        insert_key(16'h0000);
        insert_key(16'h0010);
        insert_key(16'hFFFF);
        insert_key(16'h001F);
        // duplicate key lands further down the cluster
        insert_key(16'h0000);
        // search must return the first copy on the path
        send_request(lpht_pkg::OP_SEARCH, 16'h0000);
        send_request(lpht_pkg::OP_SEARCH, 16'h001F);
        // absent key whose walk ends at the first empty slot
        send_request(lpht_pkg::OP_SEARCH, 16'h0020);
        send_request(lpht_pkg::OP_SEARCH, 16'hFFFF);
        // fill the rest, all homed on slot 3, so each walk is one longer
        for (int i = 1; i <= 11; i++)
            insert_key(lpht_pkg::key_t'((i << 8) | 16'h0053));
        // full table: insert refused, absent search walks all slots
        send_request(lpht_pkg::OP_INSERT, 16'h7777);
        send_request(lpht_pkg::OP_SEARCH, 16'h0008);
        send_request(lpht_pkg::OP_SEARCH, 16'h0B53);
        send_request(lpht_pkg::OP_SEARCH, 16'h0010);
    endtask

    task automatic run_random();
        logic           op;
        lpht_pkg::key_t k;
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == DRAIN_AT)
            begin
                // stop offering until every owed reply is back
                idle_request();
                while (sb.pending() != 0) @(posedge clk);
            end
            op = ($urandom_range(0, 4) == 0) ? lpht_pkg::OP_INSERT : lpht_pkg::OP_SEARCH;
            if (op == lpht_pkg::OP_SEARCH && $urandom_range(0, 1) == 1)
                k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            else
                k = lpht_pkg::key_t'($urandom);
            send_request(op, k);
        end
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        opcode    = lpht_pkg::OP_INSERT;
        key       = '0;
        out_ready = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        fork
            result_sink();
        join_none

        run_directed();
        run_random();
        idle_request();

        // wait out the owed replies, then watch for strays
        while (sb.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d requests: %0d inserted, %0d found, %0d not found, %0d table full",
                 requests_sent, sb.status_tally[lpht_pkg::ST_INSERTED],
                 sb.status_tally[lpht_pkg::ST_FOUND],
                 sb.status_tally[lpht_pkg::ST_NOT_FOUND],
                 sb.status_tally[lpht_pkg::ST_FULL]);
        $display("covered empty, partly filled and full table, wraparound and duplicates");
        if (sb.errors == 0)
            $display("tb_linear_probe_hash_table_top: clean");
        else
            $display("tb_linear_probe_hash_table_top: errors");
        $finish;
    end

endmodule

[files.f]
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_ctrl.sv
hw/rtl/lpht_dp.sv
hw/rtl/linear_probe_hash_table_top.sv
bench/tb_linear_probe_hash_table_top.sv
